// ===== hdl/ack_retry_two_phase_sender_defines.svh =====
// ----------------------------------------------------------------------------
// ack_retry_two_phase_sender_defines
// Assertion macros shared by the sender modules.
// ----------------------------------------------------------------------------
// every module that uses them names its clock "clock" and its reset "reset"
`ifndef ACK_RETRY_TWO_PHASE_SENDER_DEFINES_SVH
`define ACK_RETRY_TWO_PHASE_SENDER_DEFINES_SVH

// same-cycle implication
`define ARS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ARS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/ars_pkg.sv =====
// ----------------------------------------------------------------------------
// ars_pkg
// Types, constants and register map of the two-phase acknowledged sender.
// ----------------------------------------------------------------------------
package ars_pkg;

   localparam int PAYLOAD_BYTES = 6;
   localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 2;
   localparam int CRC_BITS      = 8 * PAYLOAD_BYTES;
   localparam int BIT_CNT_W     = $clog2(CRC_BITS);
   localparam int BYTE_IDX_W    = $clog2(FRAME_BYTES);

   localparam int CFG_PAYLOAD_W = 48;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [CFG_PAYLOAD_W-1:0] RED_PAYLOAD_RST   = 48'h060504030201;
   localparam logic [CFG_PAYLOAD_W-1:0] GREEN_PAYLOAD_RST = 48'h010203040506;
   localparam logic [7:0]  ACK_CODE_RST   = 8'hAC;
   localparam logic [7:0]  RESEND_RST     = 8'd5;
   localparam logic [15:0] RED_HOLD_RST   = 16'd10000;
   localparam logic [15:0] GREEN_HOLD_RST = 16'd6000;

   localparam logic [7:0] RX_FORCE_RED   = 8'h00;
   localparam logic [7:0] RX_FORCE_GREEN = 8'h01;

   localparam logic [1:0] PHASE_RED_SEND   = 2'd0;
   localparam logic [1:0] PHASE_GREEN_SEND = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_RED_PAYLOAD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_PAYLOAD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_CODE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RESEND_MS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_HOLD_MS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_HOLD_MS = 3'd5;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_RX,
      CMD_BUTTON,
      CMD_NONE
   } cmd_type;

   typedef struct packed {
      logic [CFG_PAYLOAD_W-1:0] red_payload;
      logic [CFG_PAYLOAD_W-1:0] green_payload;
      logic [7:0]               ack_code;
      logic [7:0]               resend_ms;
      logic [15:0]              red_hold_ms;
      logic [15:0]              green_hold_ms;
   } cfg_type;

   // outcome of one event: whether a frame goes out and the state after it
   typedef struct packed {
      logic       send;
      logic       red_sel;
      logic       red_on;
      logic       green_on;
      logic [1:0] phase;
   } step_type;

   typedef struct packed {
      logic init;
      logic shift;
      logic data_bit;
   } crc_ctrl_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       last;
      logic       red_on;
      logic       green_on;
      logic [1:0] phase;
   } out_type;

endpackage

// ===== hdl/ars_crc_unit.sv =====
// ----------------------------------------------------------------------------
// ars_crc_unit
// Bit-serial CRC-16 (reflected polynomial), one data bit per shift.
// ----------------------------------------------------------------------------
module ars_crc_unit
   import ars_pkg::*;
(
   input  logic         clock,
   input  crc_ctrl_type ctrl,
   output logic [15:0]  crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        fb;

   always_comb begin
      fb = crc_ff[0] ^ ctrl.data_bit;
      crc_in = crc_ff;
      if (ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.shift) begin
         crc_in = (crc_ff >> 1) ^ (fb ? CRC_POLY : 16'h0000);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

// ===== hdl/ars_phase_ctrl.sv =====
// ----------------------------------------------------------------------------
// ars_phase_ctrl
// Phase state, acknowledge flag, saturating timers and LED levels.
// ----------------------------------------------------------------------------
module ars_phase_ctrl
   import ars_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  cmd_type    cmd,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output step_type   step
);

   logic [1:0]  phase_ff, phase_in;
   logic        awaiting_ff, awaiting_in;
   logic [7:0]  since_send_ff, since_send_in;
   logic [15:0] since_hold_ff, since_hold_in;
   logic        red_on_ff, red_on_in;
   logic        green_on_ff, green_on_in;

   logic        send;
   logic        red_sel;
   logic        red_side;
   logic        do_eval;
   logic [15:0] hold;

   always_comb begin
      phase_in      = phase_ff;
      awaiting_in   = awaiting_ff;
      since_send_in = since_send_ff;
      since_hold_in = since_hold_ff;
      red_on_in     = red_on_ff;
      green_on_in   = green_on_ff;
      send          = 1'b0;
      red_sel       = 1'b1;
      do_eval       = 1'b1;
      red_side      = 1'b1;
      hold          = cfg.red_hold_ms;

      unique case (cmd)
         CMD_TICK: begin
            if (since_send_in != 8'hFF) begin
               since_send_in = since_send_in + 8'd1;
            end
            if (since_hold_in != 16'hFFFF) begin
               since_hold_in = since_hold_in + 16'd1;
            end
         end
         CMD_RX: begin
            if (rx_byte == cfg.ack_code) begin
               awaiting_in = 1'b0;
            end
            if (rx_byte == RX_FORCE_RED || rx_byte == RX_FORCE_GREEN) begin
               red_on_in   = 1'b0;
               green_on_in = 1'b0;
               awaiting_in = 1'b0;
               phase_in    = (rx_byte == RX_FORCE_RED) ? PHASE_RED_SEND : PHASE_GREEN_SEND;
               send        = 1'b1;
               red_sel     = (rx_byte == RX_FORCE_RED);
            end
         end
         CMD_BUTTON: begin
            red_on_in     = 1'b0;
            green_on_in   = 1'b0;
            phase_in      = PHASE_RED_SEND;
            awaiting_in   = 1'b1;
            since_send_in = 8'hFF;
         end
         default: begin
            do_eval = 1'b0;
         end
      endcase

      if (do_eval) begin
         // bit 1 of the phase picks the side, bit 0 marks the hold half
         red_side = !phase_in[1];
         if (!phase_in[0] && !awaiting_in) begin
            if (red_side) begin
               red_on_in = 1'b1;
            end else begin
               green_on_in = 1'b1;
            end
            phase_in      = {phase_in[1], 1'b1};
            since_hold_in = 16'd0;
         end
         if (phase_in[0]) begin
            hold = red_side ? cfg.red_hold_ms : cfg.green_hold_ms;
            if (since_hold_in >= hold) begin
               if (red_side) begin
                  red_on_in = 1'b0;
               end else begin
                  green_on_in = 1'b0;
               end
               awaiting_in   = 1'b1;
               phase_in      = red_side ? PHASE_GREEN_SEND : PHASE_RED_SEND;
               since_send_in = 8'hFF;
               red_side      = !red_side;
            end
         end
         // a later send replaces a forced one of the same event
         if (!phase_in[0] && awaiting_in && since_send_in >= cfg.resend_ms) begin
            send          = 1'b1;
            red_sel       = red_side;
            since_send_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_RED_SEND;
         awaiting_ff   <= 1'b1;
         since_send_ff <= 8'hFF;
         since_hold_ff <= 16'd0;
         red_on_ff     <= 1'b0;
         green_on_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         awaiting_ff   <= awaiting_in;
         since_send_ff <= since_send_in;
         since_hold_ff <= since_hold_in;
         red_on_ff     <= red_on_in;
         green_on_ff   <= green_on_in;
      end
   end

   assign step.send     = send;
   assign step.red_sel  = red_sel;
   assign step.red_on   = red_on_in;
   assign step.green_on = green_on_in;
   assign step.phase    = phase_in;

endmodule

// ===== hdl/ars_framer.sv =====
// ----------------------------------------------------------------------------
// ars_framer
// Sequencer that runs the payload through the CRC unit and emits the frame.
// ----------------------------------------------------------------------------
`include "ack_retry_two_phase_sender_defines.svh"

module ars_framer
   import ars_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  step_type             step,
   input  logic [PAYLOAD_W-1:0] red_payload,
   input  logic [PAYLOAD_W-1:0] green_payload,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output out_type              rsp
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CRC,
      S_SEND
   } state_type;

   state_type             state_ff;
   logic [PAYLOAD_W-1:0]  pay_ff;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff;
   logic [BYTE_IDX_W-1:0] byte_idx_ff;
   logic                  frame_ff;
   logic                  red_on_ff;
   logic                  green_on_ff;
   logic [1:0]            phase_ff;

   crc_ctrl_type          crc_ctrl;
   logic [15:0]           crc;
   logic                  last;
   logic                  crc_last;
   logic [7:0]            tx_byte;

   assign crc_ctrl.init     = (state_ff == S_IDLE) && start;
   assign crc_ctrl.shift    = (state_ff == S_CRC);
   assign crc_ctrl.data_bit = pay_ff[0];

   ars_crc_unit u_crc (
      .clock (clock),
      .ctrl  (crc_ctrl),
      .crc   (crc)
   );

   assign last     = !frame_ff || (byte_idx_ff == BYTE_IDX_W'(FRAME_BYTES - 1));
   assign crc_last = (bit_cnt_ff == BIT_CNT_W'(CRC_BITS - 1));

   always_comb begin
      if (!frame_ff) begin
         tx_byte = 8'h00;
      end else if (byte_idx_ff < BYTE_IDX_W'(PAYLOAD_BYTES)) begin
         tx_byte = pay_ff[7:0];
      end else if (byte_idx_ff == BYTE_IDX_W'(PAYLOAD_BYTES)) begin
         tx_byte = crc[7:0];
      end else begin
         tx_byte = crc[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  frame_ff    <= step.send;
                  red_on_ff   <= step.red_on;
                  green_on_ff <= step.green_on;
                  phase_ff    <= step.phase;
                  pay_ff      <= step.red_sel ? red_payload : green_payload;
                  bit_cnt_ff  <= '0;
                  byte_idx_ff <= '0;
                  state_ff    <= step.send ? S_CRC : S_SEND;
               end
            end
            S_CRC: begin
               // rotate so the payload is intact after the last bit
               pay_ff     <= {pay_ff[0], pay_ff[PAYLOAD_W-1:1]};
               bit_cnt_ff <= bit_cnt_ff + BIT_CNT_W'(1);
               if (crc_last) begin
                  state_ff <= S_SEND;
               end
            end
            S_SEND: begin
               if (rsp_ready) begin
                  if (last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     byte_idx_ff <= byte_idx_ff + BYTE_IDX_W'(1);
                     pay_ff      <= pay_ff >> 8;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = (state_ff == S_SEND);
   assign rsp.tx_valid = frame_ff;
   assign rsp.tx_byte  = tx_byte;
   assign rsp.last     = last;
   assign rsp.red_on   = red_on_ff;
   assign rsp.green_on = green_on_ff;
   assign rsp.phase    = phase_ff;

   `ARS_ASSERT_NEXT(a_crc_done, state_ff == S_CRC && crc_last, state_ff == S_SEND)
   `ARS_ASSERT_NEXT(a_last_done, state_ff == S_SEND && rsp_ready && last, state_ff == S_IDLE)
   `ARS_ASSERT_IMPL(a_no_frame_single, state_ff == S_SEND && !frame_ff, last && tx_byte == 8'h00)

endmodule

// ===== hdl/ack_retry_two_phase_sender.sv =====
// ----------------------------------------------------------------------------
// ack_retry_two_phase_sender
// Red/green phase sender: framed, CRC-protected, resent until acknowledged.
// ----------------------------------------------------------------------------
// Usage
//   req channel carries one event per transaction: tuser holds the kind (tick,
//   received byte, button), tdata the received byte. rsp channel returns the
//   results of that event: either one idle result or the eight bytes of a
//   frame (six payload bytes, CRC low, CRC high), tlast on the final one.
//   Every result also reports the LED levels and the phase after the event.
//   The CSR port sets payloads, acknowledge code, resend interval and holds.
// Timing
//   An event without a frame: its result is offered the cycle after the
//   transaction. An event with a frame: the single CRC unit takes the
//   payload one bit at a time, then the 8 bytes go out one per cycle while
//   the receiver is ready.
//   req_tready is low from the transaction until the last result is taken.
// Reset and stall
//   Reset restores the settings, timers, LED levels and the red send phase.
//   A stalled receiver holds the current result stable; nothing is dropped.
// ----------------------------------------------------------------------------
`include "ack_retry_two_phase_sender_defines.svh"

module ack_retry_two_phase_sender
   import ars_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // rx_byte
   input  logic [1:0]            req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // tx_byte, red_led, green_led, phase, zero fill
   output logic                  rsp_tuser,   // tx_valid
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type                cfg_ff;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   accept;
   logic                   busy;
   step_type               step;
   out_type                rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_INDEX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_payload   <= RED_PAYLOAD_RST;
         cfg_ff.green_payload <= GREEN_PAYLOAD_RST;
         cfg_ff.ack_code      <= ACK_CODE_RST;
         cfg_ff.resend_ms     <= RESEND_RST;
         cfg_ff.red_hold_ms   <= RED_HOLD_RST;
         cfg_ff.green_hold_ms <= GREEN_HOLD_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RED_PAYLOAD:   cfg_ff.red_payload   <= csr_pwdata[CFG_PAYLOAD_W-1:0];
            REG_GREEN_PAYLOAD: cfg_ff.green_payload <= csr_pwdata[CFG_PAYLOAD_W-1:0];
            REG_ACK_CODE:      cfg_ff.ack_code      <= csr_pwdata[7:0];
            REG_RESEND_MS:     cfg_ff.resend_ms     <= csr_pwdata[7:0];
            REG_RED_HOLD_MS:   cfg_ff.red_hold_ms   <= csr_pwdata[15:0];
            REG_GREEN_HOLD_MS: cfg_ff.green_hold_ms <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_RED_PAYLOAD:   csr_prdata = CSR_DATA_W'(cfg_ff.red_payload);
         REG_GREEN_PAYLOAD: csr_prdata = CSR_DATA_W'(cfg_ff.green_payload);
         REG_ACK_CODE:      csr_prdata = CSR_DATA_W'(cfg_ff.ack_code);
         REG_RESEND_MS:     csr_prdata = CSR_DATA_W'(cfg_ff.resend_ms);
         REG_RED_HOLD_MS:   csr_prdata = CSR_DATA_W'(cfg_ff.red_hold_ms);
         REG_GREEN_HOLD_MS: csr_prdata = CSR_DATA_W'(cfg_ff.green_hold_ms);
         default:           csr_prdata = '0;
      endcase
   end

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   ars_phase_ctrl u_phase (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (cmd_type'(req_tuser)),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .step    (step)
   );

   ars_framer u_framer (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .step          (step),
      .red_payload   (cfg_ff.red_payload[PAYLOAD_W-1:0]),
      .green_payload (cfg_ff.green_payload[PAYLOAD_W-1:0]),
      .busy          (busy),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp)
   );

   assign rsp_tdata = {4'b0000, rsp.phase, rsp.green_on, rsp.red_on, rsp.tx_byte};
   assign rsp_tuser = rsp.tx_valid;
   assign rsp_tlast = rsp.last;

   `ARS_ASSERT_IMPL(a_busy_not_ready, rsp_tvalid, !req_tready)
   `ARS_ASSERT_IMPL(a_led_exclusive, rsp_tvalid, !(rsp.red_on && rsp.green_on))
   `ARS_ASSERT_NEXT(a_accept_busy, accept, !req_tready)

endmodule

// ===== tb/ack_retry_two_phase_sender_test.sv =====
// ----------------------------------------------------------------------------
// ack_retry_two_phase_sender_test
// Self-checking bench for the red/green acknowledged frame sender: events go
// in on the req stream, a behavioural copy of the phase logic and the CRC
// predicts every frame byte and idle result, and the rsp stream is checked
// in order. CSR settings change between phases, with bursty traffic and
// receiver stalls throughout.
// ----------------------------------------------------------------------------
module ack_retry_two_phase_sender_test
   import ars_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] rx;
   } event_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;   // rx_byte
   logic [1:0]            req_tuser = 2'b00;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;           // tx_byte, red_led, green_led, phase, zero fill
   logic                  rsp_tuser;           // tx_valid
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ack_retry_two_phase_sender DUT (.*);

   // predicted block state and settings
   cfg_type     setting = '{RED_PAYLOAD_RST, GREEN_PAYLOAD_RST, ACK_CODE_RST,
                            RESEND_RST, RED_HOLD_RST, GREEN_HOLD_RST};
   logic [1:0]  phase_q = PHASE_RED_SEND;
   logic        awaiting = 1'b1;
   logic [7:0]  since_send = 8'hFF;
   logic [15:0] since_hold = 16'h0000;
   logic        red_lit = 1'b0;
   logic        green_lit = 1'b0;

   event_item_type events_pending[$];
   out_type        results_due[$];
   event_item_type on_offer;
   int          burst_left = 1;
   int          gap_left = 0;
   int          fail_count = 0;
   int          long_stall_reqs = 0;
   int          long_stall_done = 0;
   int          long_stall_left = 0;
   int          ready_mode = 0;
   int          mode_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void note_failure(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t mismatch, %s: expected %h, got %h", $realtime, what, want, got);
   endfunction

   function automatic logic [15:0] modbus_crc(input logic [PAYLOAD_W-1:0] payload);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         c = c ^ {8'h00, payload[8*i +: 8]};
         for (int b = 0; b < 8; b++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // phase logic run after every tick, received byte and button; a later frame replaces an earlier one
   function automatic void settle_phase(inout logic send, inout logic [PAYLOAD_W-1:0] payload);
      logic        red_side;
      logic [15:0] hold;
      red_side = !phase_q[1];
      if (!phase_q[0] && !awaiting) begin
         if (red_side) red_lit = 1'b1;
         else green_lit = 1'b1;
         phase_q[0] = 1'b1;
         since_hold = 16'h0000;
      end
      if (phase_q[0]) begin
         hold = red_side ? setting.red_hold_ms : setting.green_hold_ms;
         if (since_hold >= hold) begin
            if (red_side) red_lit = 1'b0;
            else green_lit = 1'b0;
            awaiting = 1'b1;
            phase_q = red_side ? PHASE_GREEN_SEND : PHASE_RED_SEND;
            since_send = 8'hFF;
            red_side = !red_side;
         end
      end
      if (!phase_q[0] && awaiting && since_send >= setting.resend_ms) begin
         send = 1'b1;
         payload = red_side ? setting.red_payload : setting.green_payload;
         since_send = 8'h00;
      end
   endfunction

   function automatic void advance_sender(input cmd_type cmd, input logic [7:0] rx);
      logic                 send;
      logic [PAYLOAD_W-1:0] payload;
      logic [15:0]          crc;
      out_type              r;
      send = 1'b0;
      payload = '0;
      case (cmd)
         CMD_TICK: begin
            if (since_send != 8'hFF) since_send++;
            if (since_hold != 16'hFFFF) since_hold++;
            settle_phase(send, payload);
         end
         CMD_RX: begin
            if (rx == setting.ack_code) awaiting = 1'b0;
            if (rx == RX_FORCE_RED || rx == RX_FORCE_GREEN) begin
               red_lit = 1'b0;
               green_lit = 1'b0;
               awaiting = 1'b0;
               phase_q = (rx == RX_FORCE_RED) ? PHASE_RED_SEND : PHASE_GREEN_SEND;
               send = 1'b1;
               payload = (rx == RX_FORCE_RED) ? setting.red_payload : setting.green_payload;
            end
            settle_phase(send, payload);
         end
         CMD_BUTTON: begin
            red_lit = 1'b0;
            green_lit = 1'b0;
            phase_q = PHASE_RED_SEND;
            awaiting = 1'b1;
            since_send = 8'hFF;
            settle_phase(send, payload);
         end
         default: ;
      endcase
      r.red_on = red_lit;
      r.green_on = green_lit;
      r.phase = phase_q;
      if (send) begin
         crc = modbus_crc(payload);
         for (int k = 0; k < FRAME_BYTES; k++) begin
            r.tx_valid = 1'b1;
            r.tx_byte = (k < PAYLOAD_BYTES) ? payload[8*k +: 8] :
                        (k == PAYLOAD_BYTES) ? crc[7:0] : crc[15:8];
            r.last = (k == FRAME_BYTES - 1);
            results_due.push_back(r);
         end
      end else begin
         r.tx_valid = 1'b0;
         r.tx_byte = 8'h00;
         r.last = 1'b1;
         results_due.push_back(r);
      end
   endfunction

   // event source: bursts of random length with random gaps
   always @(posedge clock) begin : drive_req
      event_item_type nxt;
      logic           offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            advance_sender(on_offer.cmd, on_offer.rx);
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (events_pending.size() > 0) begin
               nxt = events_pending.pop_front();
               on_offer = nxt;
               req_tuser <= nxt.cmd;
               req_tdata <= nxt.rx;
               offer = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
            req_tvalid <= offer;
         end
      end
   end

   // receiver stall pattern, plus the occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall_left > 0) begin
         long_stall_left--;
         rsp_tready <= 1'b0;
      end else if (long_stall_reqs != long_stall_done) begin
         long_stall_done++;
         long_stall_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= $urandom_range(0, 1);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin : watch_rsp
      out_type     want;
      logic [15:0] want_data;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            note_failure("result with nothing due", 64'h0,
                         64'({rsp_tlast, rsp_tuser, rsp_tdata}));
         end else begin
            want = results_due.pop_front();
            want_data = {4'b0000, want.phase, want.green_on, want.red_on, want.tx_byte};
            if (rsp_tdata !== want_data || rsp_tuser !== want.tx_valid ||
                rsp_tlast !== want.last)
               note_failure("rsp {tlast,tuser,tdata}",
                            64'({want.last, want.tx_valid, want_data}),
                            64'({rsp_tlast, rsp_tuser, rsp_tdata}));
         end
      end
   end

   // write a register, then read it back
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_RED_PAYLOAD:   setting.red_payload = value[CFG_PAYLOAD_W-1:0];
         REG_GREEN_PAYLOAD: setting.green_payload = value[CFG_PAYLOAD_W-1:0];
         REG_ACK_CODE:      setting.ack_code = value[7:0];
         REG_RESEND_MS:     setting.resend_ms = value[7:0];
         REG_RED_HOLD_MS:   setting.red_hold_ms = value[15:0];
         REG_GREEN_HOLD_MS: setting.green_hold_ms = value[15:0];
         default: ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value)
         note_failure($sformatf("csr readback of register %0d", index), value, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // sender pause: nothing queued, nothing offered, every result back
   task automatic drain();
      while (events_pending.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_event(input cmd_type cmd, input logic [7:0] rx);
      event_item_type e;
      e.cmd = cmd;
      e.rx = rx;
      events_pending.push_back(e);
   endtask

   function automatic event_item_type random_event();
      event_item_type e;
      int             pick;
      pick = $urandom_range(0, 99);
      e.rx = 8'($urandom_range(0, 255));
      if (pick < 55) begin
         e.cmd = CMD_TICK;
      end else if (pick < 75) begin
         e.cmd = CMD_RX;
         e.rx = setting.ack_code;
      end else if (pick < 80) begin
         e.cmd = CMD_RX;
         e.rx = $urandom_range(0, 1) ? RX_FORCE_GREEN : RX_FORCE_RED;
      end else if (pick < 90) begin
         e.cmd = CMD_RX;
      end else if (pick < 95) begin
         e.cmd = CMD_BUTTON;
      end else begin
         e.cmd = CMD_NONE;
      end
      return e;
   endfunction

   initial begin : run_phases
      logic [7:0]  ack_pick;
      logic [15:0] red_hold_pick;
      logic [15:0] green_hold_pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // reset settings: first tick sends, acknowledge, forced phases, button
      queue_event(CMD_TICK, 8'h00);
      queue_event(CMD_TICK, 8'hFF);
      queue_event(CMD_RX, 8'h55);
      queue_event(CMD_RX, ACK_CODE_RST);
      queue_event(CMD_RX, ACK_CODE_RST);   // acknowledge during hold
      queue_event(CMD_TICK, 8'hAA);
      queue_event(CMD_BUTTON, 8'h00);
      queue_event(CMD_RX, RX_FORCE_GREEN);
      queue_event(CMD_RX, RX_FORCE_RED);
      queue_event(CMD_NONE, 8'hFF);
      queue_event(CMD_RX, 8'hFF);
      queue_event(CMD_BUTTON, 8'hFF);
      drain();

      // extremes: empty and full payloads, resend interval and holds of one
      csr_write(REG_RED_PAYLOAD, 64'h0);
      csr_write(REG_GREEN_PAYLOAD, 64'h0000_FFFF_FFFF_FFFF);
      csr_write(REG_ACK_CODE, 64'hFF);
      csr_write(REG_RESEND_MS, 64'd1);
      csr_write(REG_RED_HOLD_MS, 64'd1);
      csr_write(REG_GREEN_HOLD_MS, 64'd1);
      queue_event(CMD_TICK, 8'h00);
      queue_event(CMD_TICK, 8'h00);
      queue_event(CMD_RX, 8'hFF);
      queue_event(CMD_TICK, 8'h0F);        // hold expires, green frame at once
      queue_event(CMD_RX, 8'hFF);
      queue_event(CMD_TICK, 8'hF0);
      queue_event(CMD_RX, RX_FORCE_RED);
      queue_event(CMD_TICK, 8'h00);
      queue_event(CMD_TICK, 8'h00);
      queue_event(CMD_RX, RX_FORCE_GREEN);
      queue_event(CMD_TICK, 8'h00);
      queue_event(CMD_TICK, 8'h00);
      drain();

      for (int p = 0; p < 7; p++) begin
         if (p == 3) begin
            // longest resend interval and holds, mostly ticks
            csr_write(REG_ACK_CODE, {56'h0, RX_FORCE_RED});
            csr_write(REG_RESEND_MS, 64'd255);
            csr_write(REG_RED_HOLD_MS, 64'hFFFF);
            csr_write(REG_GREEN_HOLD_MS, 64'hFFFF);
            queue_event(CMD_BUTTON, 8'h00);
            for (int i = 0; i < 30; i++)
               if ($urandom_range(0, 29) == 0) queue_event(CMD_RX, 8'($urandom_range(2, 255)));
               else queue_event(CMD_TICK, 8'($urandom_range(0, 255)));
            queue_event(CMD_RX, RX_FORCE_RED);
            queue_event(CMD_RX, RX_FORCE_GREEN);
         end else begin
            case ($urandom_range(0, 3))
               0:       ack_pick = RX_FORCE_RED;
               1:       ack_pick = RX_FORCE_GREEN;
               2:       ack_pick = 8'hFF;
               default: ack_pick = 8'($urandom_range(0, 255));
            endcase
            red_hold_pick = ($urandom_range(0, 7) == 0) ? 16'hFFFF :
                            16'($urandom_range(1, 6));
            green_hold_pick = ($urandom_range(0, 7) == 0) ? 16'hFFFF :
                              16'($urandom_range(1, 6));
            csr_write(REG_RED_PAYLOAD,
                      {16'h0, 16'($urandom_range(0, 65535)), 32'($urandom())});
            csr_write(REG_GREEN_PAYLOAD,
                      {16'h0, 16'($urandom_range(0, 65535)), 32'($urandom())});
            csr_write(REG_ACK_CODE, {56'h0, ack_pick});
            csr_write(REG_RESEND_MS, ($urandom_range(0, 7) == 0) ? 64'd255 :
                                     64'($urandom_range(1, 4)));
            csr_write(REG_RED_HOLD_MS, {48'h0, red_hold_pick});
            csr_write(REG_GREEN_HOLD_MS, {48'h0, green_hold_pick});
            if (p == 1) long_stall_reqs++;
            for (int i = 0; i < 20; i++)
               events_pending.push_back(random_event());
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && results_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
